>>> design/rqbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rqbp_pkg;

    // Default sizes of the ring.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // A get_all request gives at most this many items.
    localparam logic [3:0] MAX_RESULTS = 4'd15;

    // Request codes.
    localparam logic [2:0] REQ_PUT     = 3'd0;
    localparam logic [2:0] REQ_TAKE    = 3'd1;
    localparam logic [2:0] REQ_TOP     = 3'd2;
    localparam logic [2:0] REQ_POP     = 3'd3;
    localparam logic [2:0] REQ_POP_N   = 3'd4;
    localparam logic [2:0] REQ_GET_ALL = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD_POP = 2'd3;

    // One request item.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] put_value;
        logic [4:0]  pop_count;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [3:0]  slot_index;
        logic [3:0]  run_length;
        logic [3:0]  fill_count;
        logic [3:0]  peak_fill;
        logic [63:0] total_popped;
        logic        last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic advance;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;
    } t_ctrl_stat;

endpackage

`default_nettype wire

>>> design/rqbp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rqbp_ctrl
    import rqbp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_ctrl_stat i_stat,
    output t_ctrl_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Handshakes follow directly from the state.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.advance = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_stall) begin
                    if (i_stat.more) begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/rqbp_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rqbp_dp
    import rqbp_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_ctrl_cmd  i_cmd,
    input  wire t_in_item   i_item,
    output t_ctrl_stat      o_stat,
    output t_out_item       o_item
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SUM_W = IDX_W + 6;

    // Ring storage and its read register.
    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Ring state.
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [IDX_W-1:0] r_peak;
    logic [63:0]      r_total;
    logic [IDX_W-1:0] n_wr_ptr;
    logic [IDX_W-1:0] n_rd_ptr;
    logic [IDX_W-1:0] n_peak;
    logic [63:0]      n_total;

    // Request in flight and get_all stream position.
    t_in_item         r_req;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W:0]   r_run;
    logic [3:0]       r_left;
    logic             r_more;
    t_out_item        r_out;

    logic [IDX_W-1:0]      fill;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W:0]        run;
    logic [3:0]            count;
    logic [SUM_W-1:0]      pn_sum;
    logic                  we;
    logic                  more;
    logic [1:0]            st;
    logic [DATA_WIDTH-1:0] val;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W:0]        runl;
    logic                  last;

    assign fill = r_wr_ptr - r_rd_ptr;

    // Contiguous run from the read slot, and how many items it gives.
    always_comb begin
        if (r_wr_ptr >= r_rd_ptr) begin
            run = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr};
        end else begin
            run = (IDX_W + 1)'(CAPACITY) - {1'b0, r_rd_ptr};
        end
        if (run > (IDX_W + 1)'(MAX_RESULTS)) begin
            count = MAX_RESULTS;
        end else begin
            count = 4'(run);
        end
    end

    // The read address always follows the slot that the next item looks at.
    always_comb begin
        if (i_cmd.load) begin
            rd_addr = r_rd_ptr;
        end else if (i_cmd.advance) begin
            rd_addr = r_ptr + 1'b1;
        end else begin
            rd_addr = r_ptr;
        end
    end

    // Memory write by put, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            r_mem[r_wr_ptr] <= DATA_WIDTH'(r_req.put_value);
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign pn_sum = SUM_W'(r_rd_ptr) + SUM_W'(r_req.pop_count);

    // Execution of the request in flight.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_peak   = r_peak;
        n_total  = r_total;
        we       = 1'b0;
        more     = 1'b0;
        st       = ST_OK;
        val      = '0;
        slot     = '0;
        runl     = '0;
        last     = 1'b1;
        case (r_req.req_type)
            REQ_PUT: begin
                if (fill == {IDX_W{1'b1}}) begin
                    st = ST_FULL;
                end else begin
                    if (fill > r_peak) begin
                        n_peak = fill;
                    end
                    we       = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                end
            end
            REQ_TAKE, REQ_TOP: begin
                if (fill == '0) begin
                    st = ST_EMPTY;
                end else begin
                    val  = r_rd_data;
                    slot = r_rd_ptr;
                    if (r_req.req_type == REQ_TAKE) begin
                        n_rd_ptr = r_rd_ptr + 1'b1;
                    end
                end
            end
            REQ_POP: begin
                if (fill == '0) begin
                    st = ST_EMPTY;
                end else begin
                    n_total  = r_total + 64'd1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                end
            end
            REQ_POP_N: begin
                if ((SUM_W'(fill) < SUM_W'(r_req.pop_count))
                        || (pn_sum > SUM_W'(CAPACITY))) begin
                    st = ST_BAD_POP;
                end else begin
                    n_total  = r_total + 64'(r_req.pop_count);
                    n_rd_ptr = pn_sum[IDX_W-1:0];
                end
            end
            REQ_GET_ALL: begin
                if (fill == '0) begin
                    st = ST_EMPTY;
                end else begin
                    val  = r_rd_data;
                    slot = r_ptr;
                    runl = r_run;
                    last = (r_left == 4'd1);
                    more = !last;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    // Ring state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_peak   <= '0;
            r_total  <= '0;
            r_more   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_peak   <= n_peak;
            r_total  <= n_total;
            r_more   <= more;
        end
    end

    // Request capture, stream stepping and the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_item;
            r_ptr  <= r_rd_ptr;
            r_run  <= run;
            r_left <= count;
        end else if (i_cmd.advance) begin
            r_ptr  <= r_ptr + 1'b1;
            r_left <= r_left - 4'd1;
        end
        if (i_cmd.exec) begin
            r_out.status       <= st;
            r_out.read_value   <= 32'(val);
            r_out.slot_index   <= 4'(slot);
            r_out.run_length   <= 4'(runl);
            r_out.fill_count   <= 4'(n_wr_ptr - n_rd_ptr);
            r_out.peak_fill    <= 4'(n_peak);
            r_out.total_popped <= n_total;
            r_out.last         <= last;
        end
    end

    assign o_stat.more = r_more;
    assign o_item      = r_out;

endmodule

`default_nettype wire

>>> design/ring_queue_with_batch_pop.sv
// Each request is accepted, then executed, then presented.
// Its first result is valid in the present state, which follows the execute state.
// A get_all run gives each further result after another execute state, once the previous one is taken.
// One request is in the block at a time; the request port stalls until its last result goes.
// Synchronous active-low reset empties the ring and clears the peak and popped totals.
`timescale 1ns / 1ps
`default_nettype none

module ring_queue_with_batch_pop
    import rqbp_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    // Sequencer for request, execution and result hand-off.
    rqbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Ring storage, pointers and counters.
    rqbp_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_item),
        .o_stat  (stat),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> tb/ring_queue_with_batch_pop_tb.sv
`timescale 1ns / 1ps

module ring_queue_with_batch_pop_tb;
    import rqbp_pkg::*;

    localparam int DEPTH          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 420;
    localparam int WATCHDOG_LIMIT = 2000;

    // Request codes that the block does not define; it answers them with a plain ok.
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    // Shadow copy of the ring: it works out the result items that each request owes
    // and compares them, in order, with what the block gives.
    class queue_shadow;
        logic [31:0] slot_words [DEPTH];
        logic [3:0]  wr_ptr;
        logic [3:0]  rd_ptr;
        logic [3:0]  peak_level;
        logic [63:0] popped_total;
        t_out_item   owed_results [$];
        int          mismatches;
        int          results_seen;

        function new();
            wr_ptr       = '0;
            rd_ptr       = '0;
            peak_level   = '0;
            popped_total = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function logic [3:0] fill();
            return wr_ptr - rd_ptr;
        endfunction

        // The occupancy, peak and total reported are those after the request.
        function void owe(logic [1:0] status, logic [31:0] word, logic [3:0] slot,
                          logic [3:0] run, logic last);
            t_out_item item;
            item.status       = status;
            item.read_value   = word;
            item.slot_index   = slot;
            item.run_length   = run;
            item.fill_count   = fill();
            item.peak_fill    = peak_level;
            item.total_popped = popped_total;
            item.last         = last;
            owed_results.push_back(item);
        endfunction

        function void note_request(t_in_item req);
            logic [3:0] level;
            logic [3:0] tail;
            int         n;
            int         run;
            int         count;
            int         i;
            level = fill();
            tail  = rd_ptr;
            n     = int'(req.pop_count);
            case (req.req_type)
                REQ_PUT: begin
                    if (level == 4'(DEPTH - 1)) begin
                        owe(ST_FULL, '0, '0, '0, 1'b1);
                    end else begin
                        // The peak is sampled before the word goes in.
                        if (level > peak_level) begin
                            peak_level = level;
                        end
                        slot_words[wr_ptr] = req.put_value;
                        wr_ptr = wr_ptr + 4'd1;
                        owe(ST_OK, '0, '0, '0, 1'b1);
                    end
                end
                REQ_TAKE, REQ_TOP: begin
                    if (level == 0) begin
                        owe(ST_EMPTY, '0, '0, '0, 1'b1);
                    end else begin
                        if (req.req_type == REQ_TAKE) begin
                            rd_ptr = tail + 4'd1;
                        end
                        owe(ST_OK, slot_words[tail], tail, '0, 1'b1);
                    end
                end
                REQ_POP: begin
                    if (level == 0) begin
                        owe(ST_EMPTY, '0, '0, '0, 1'b1);
                    end else begin
                        popped_total = popped_total + 64'd1;
                        rd_ptr = tail + 4'd1;
                        owe(ST_OK, '0, '0, '0, 1'b1);
                    end
                end
                REQ_POP_N: begin
                    // Refused when it asks for more than is held or would run past
                    // the end of the array.
                    if (n > int'(level) || int'(tail) + n > DEPTH) begin
                        owe(ST_BAD_POP, '0, '0, '0, 1'b1);
                    end else begin
                        popped_total = popped_total + 64'(n);
                        rd_ptr = tail + 4'(n);
                        owe(ST_OK, '0, '0, '0, 1'b1);
                    end
                end
                REQ_GET_ALL: begin
                    if (level == 0) begin
                        owe(ST_EMPTY, '0, '0, '0, 1'b1);
                    end else begin
                        // Only the run up to the write slot or the array end is given.
                        run = (wr_ptr >= tail) ? int'(wr_ptr) - int'(tail)
                                               : DEPTH - int'(tail);
                        count = (run > int'(MAX_RESULTS)) ? int'(MAX_RESULTS) : run;
                        for (i = 0; i < count; i++) begin
                            owe(ST_OK, slot_words[tail + 4'(i)], tail + 4'(i), 4'(run),
                                i == count - 1);
                        end
                    end
                end
                default: begin
                    owe(ST_OK, '0, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (owed_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: result item with none owed, expected nothing, actual 0x%h",
                         $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("run_length", want.run_length, got.run_length);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("peak_fill", want.peak_fill, got.peak_fill);
            compare_field("total_popped", want.total_popped, got.total_popped);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    queue_shadow shadow = new();
    int          req_count [8];
    int          idle_cycles = 0;

    ring_queue_with_batch_pop u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Clock.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one request, hold it until taken, then idle for a random gap.
    task automatic send(logic [2:0] kind, logic [31:0] word, logic [4:0] count);
        int gap;
        in_item  = '{req_type: kind, put_value: word, pop_count: count};
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        shadow.note_request(in_item);
        req_count[kind]++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold the request side quiet until every owed result item has arrived.
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (shadow.owed_results.size() != 0) @(negedge clk);
    endtask

    // One random request; the put share sets whether the ring tends to fill or drain.
    task automatic send_random(bit filling);
        int          roll;
        int          room;
        int          n;
        logic [31:0] word;
        word = $urandom;
        case ($urandom_range(0, 9))
            0: word = '0;
            1: word = '1;
            default: ;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 70 : 15)) begin
            send(REQ_PUT, word, 5'($urandom));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 18) begin
                send(REQ_TAKE, word, 5'($urandom));
            end else if (roll < 30) begin
                send(REQ_TOP, word, 5'($urandom));
            end else if (roll < 48) begin
                send(REQ_POP, word, 5'($urandom));
            end else if (roll < 75) begin
                // Mostly a count that fits, sometimes any count at all.
                room = int'(shadow.fill());
                if (DEPTH - int'(shadow.rd_ptr) < room) begin
                    room = DEPTH - int'(shadow.rd_ptr);
                end
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, room);
                send(REQ_POP_N, word, 5'(n));
            end else if (roll < 95) begin
                send(REQ_GET_ALL, word, 5'($urandom));
            end else begin
                send($urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI, word,
                     5'($urandom));
            end
        end
    endtask

    // Result side: check every item taken from the block.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            shadow.check_result(out_item);
        end
    end

    // Result side back-pressure: short and long stalls, with quiet stretches.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 7) == 0) begin
                out_stall = 1'b0;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            out_stall = (pick_gap() > 0);
            repeat ($urandom_range(1, 4)) @(negedge clk);
            if (out_stall && $urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(8, 30)) @(negedge clk);
            end
            out_stall = 1'b0;
        end
    end

    // Watchdog: the run ends if no item moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
            $display("** ring_queue_with_batch_pop: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        int k;
        bit filling;
        in_valid = 1'b0;
        in_item  = '0;
        rst_n    = 1'b0;
        filling  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Every read-type request and a batch pop on an empty ring, then a spare code.
        send(REQ_TAKE, '0, '0);
        send(REQ_TOP, '0, '0);
        send(REQ_POP, '0, '0);
        send(REQ_GET_ALL, '0, '0);
        send(REQ_POP_N, '0, 5'd31);
        send(REQ_SPARE_LO, '1, 5'd31);

        // Fill to capacity with extreme words first, then one put too many.
        for (k = 0; k < DEPTH - 1; k++) begin
            send(REQ_PUT, (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom, '0);
        end
        send(REQ_PUT, 32'hDEAD_BEEF, '0);

        // The longest run, a batch pop beyond the fill, and a batch pop of all.
        send(REQ_GET_ALL, '0, '0);
        send(REQ_POP_N, '0, 5'd16);
        send(REQ_POP_N, '0, 5'd15);

        // Wrap the write slot past the array end: the run stops at the end and a
        // batch pop that would cross it is refused.
        send(REQ_PUT, 32'h1234_5678, '0);
        send(REQ_PUT, 32'h8765_4321, '0);
        send(REQ_GET_ALL, '0, '0);
        send(REQ_POP_N, '0, 5'd2);
        wait_for_results();

        // Random traffic, swinging between filling and draining the ring.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 40 == 0) begin
                filling = !filling;
            end
            if (k % 140 == 139) begin
                wait_for_results();
            end
            send_random(filling);
        end

        wait_for_results();
        repeat (20) @(negedge clk);

        $display("Requests sent: put %0d, take %0d, top %0d, pop %0d, pop_n %0d,",
                 req_count[REQ_PUT], req_count[REQ_TAKE], req_count[REQ_TOP],
                 req_count[REQ_POP], req_count[REQ_POP_N]);
        $display("  get_all %0d, spare %0d; result items checked under random gaps",
                 req_count[REQ_GET_ALL], req_count[REQ_SPARE_LO] + req_count[REQ_SPARE_HI]);
        $display("  and stalls: %0d, mismatches: %0d.",
                 shadow.results_seen, shadow.mismatches);
        if (shadow.mismatches == 0) begin
            $display("** ring_queue_with_batch_pop: PASSED **");
        end else begin
            $display("** ring_queue_with_batch_pop: FAILED **");
        end
        $finish;
    end

endmodule
